// ----- sv/ppms_pkg.sv -----
`timescale 1ns / 1ps

package ppms_pkg;

  // Widths and sizes of the datapath
  localparam int MAX_OPERANDS = 8;
  localparam int VALUE_WIDTH  = 32;
  localparam int CFG_W        = 4;
  localparam int CMP_W        = CFG_W + 1;
  localparam int CNT_W        = $clog2(MAX_OPERANDS + 1);
  localparam int TREE_LVLS    = (MAX_OPERANDS > 1) ? $clog2(MAX_OPERANDS) : 1;
  localparam int LEAVES       = 2 ** TREE_LVLS;
  localparam int NUM_STAGES   = TREE_LVLS + 1;

  // Operand count after reset
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef val_t val_vec_t [MAX_OPERANDS];

  // One candidate for the mode: how often a value occurs, and the value
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    val_t             val;
  } cand_t;

endpackage

// ----- sv/per_pixel_mode_select_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_value_0..7, in_null_flags
// out_      output     out_valid / out_stall out_mode_value, out_result_null
// cfg_      input      cfg_write_en          cfg_write_data (operand count)
//
// One pixel enters per cycle while in_stall is low; each result is registered
// first by the lane compare-and-count, then by each level of the registered
// max tree that merges the lanes.
// Synchronous active-low reset empties the pipeline and sets operand count to 8.
// A stalled output holds the pipeline only as far back as it is full; empty
// stages still take new pixels.

module per_pixel_mode_select_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ppms_pkg::val_t                      in_value_0,
  input  ppms_pkg::val_t                      in_value_1,
  input  ppms_pkg::val_t                      in_value_2,
  input  ppms_pkg::val_t                      in_value_3,
  input  ppms_pkg::val_t                      in_value_4,
  input  ppms_pkg::val_t                      in_value_5,
  input  ppms_pkg::val_t                      in_value_6,
  input  ppms_pkg::val_t                      in_value_7,
  input  logic [ppms_pkg::MAX_OPERANDS-1:0]   in_null_flags,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ppms_pkg::val_t                      out_mode_value,
  output logic                                out_result_null,
  input  logic                                cfg_write_en,
  input  logic [ppms_pkg::CFG_W-1:0]          cfg_write_data
);

  localparam int NST = ppms_pkg::NUM_STAGES;

  logic [ppms_pkg::CFG_W-1:0]        operand_count_r;
  logic [ppms_pkg::MAX_OPERANDS-1:0] used;
  ppms_pkg::val_vec_t                in_vals;
  logic [NST:0]                      ready;
  logic [NST-1:0]                    valid_r;
  logic [NST-1:0]                    valid_nxt;
  logic [NST-1:0]                    null_r;
  logic                              null_in;
  ppms_pkg::cand_t                   tree [2*ppms_pkg::LEAVES-1];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operand_count_r <= ppms_pkg::CFG_RESET;
    end else if (cfg_write_en) begin
      operand_count_r <= cfg_write_data;
    end
  end

  // Mark the leading elements in use; a count of zero still uses the first
  always_comb begin
    for (int i = 0; i < ppms_pkg::MAX_OPERANDS; i++) begin
      used[i] = (i == 0) || ({1'b0, operand_count_r} > ppms_pkg::CMP_W'(i));
    end
    null_in = |(in_null_flags & used);
  end

  assign in_vals[0] = in_value_0;
  assign in_vals[1] = in_value_1;
  assign in_vals[2] = in_value_2;
  assign in_vals[3] = in_value_3;
  assign in_vals[4] = in_value_4;
  assign in_vals[5] = in_value_5;
  assign in_vals[6] = in_value_6;
  assign in_vals[7] = in_value_7;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    ready[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
    valid_nxt[0] = ready[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NST; k++) begin
      if (ready[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Carry the null flag alongside the candidates
  always_ff @(posedge clk) begin
    if (ready[0]) begin
      null_r[0] <= null_in;
    end
    for (int k = 1; k < NST; k++) begin
      if (ready[k]) begin
        null_r[k] <= null_r[k-1];
      end
    end
  end

  // Lanes fill the leaves; padding leaves never win
  for (genvar i = 0; i < ppms_pkg::LEAVES; i++) begin : g_leaf
    if (i < ppms_pkg::MAX_OPERANDS) begin : g_lane
      ppms_lane u_lane (
        .clk      (clk),
        .en       (ready[0]),
        .own_used (used[i]),
        .own_val  (in_vals[i]),
        .vals     (in_vals),
        .used     (used),
        .cand_r   (tree[ppms_pkg::LEAVES-1+i])
      );
    end else begin : g_pad
      assign tree[ppms_pkg::LEAVES-1+i] = '0;
    end
  end

  // Registered merge tree, one level per stage, root at index zero
  for (genvar k = 0; k < ppms_pkg::LEAVES - 1; k++) begin : g_node
    localparam int DEPTH = $clog2(k + 2) - 1;
    ppms_node u_node (
      .clk (clk),
      .en  (ready[ppms_pkg::TREE_LVLS-DEPTH]),
      .a   (tree[2*k+1]),
      .b   (tree[2*k+2]),
      .y_r (tree[k])
    );
  end

  // Drive the result from the last stage
  assign in_stall        = !ready[0];
  assign out_valid       = valid_r[NST-1];
  assign out_result_null = null_r[NST-1];
  assign out_mode_value  = null_r[NST-1] ? '0 : tree[0].val;

  // A non-null result always comes from a used element
  a_root_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_null |-> tree[0].cnt != '0)
    else $error("mode result without any matching element");

  // The winning count never exceeds the number of lanes
  a_root_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> tree[0].cnt <= ppms_pkg::CNT_W'(ppms_pkg::MAX_OPERANDS))
    else $error("mode count out of range");

  // Input stalls only when every stage holds a transaction
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> &valid_r)
    else $error("input stalled with an empty stage");

  // An unstalled output transaction leaves the last stage unless a new one follows
  a_out_drain : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !valid_r[NST-2] |=> !out_valid)
    else $error("output transaction repeated");

endmodule

// ----- sv/ppms_lane.sv -----
`timescale 1ns / 1ps

module ppms_lane (
  input  logic              clk,
  input  logic              en,
  input  logic              own_used,
  input  ppms_pkg::val_t    own_val,
  input  ppms_pkg::val_vec_t vals,
  input  logic [ppms_pkg::MAX_OPERANDS-1:0] used,
  output ppms_pkg::cand_t   cand_r
);

  ppms_pkg::cand_t cand_nxt;

  // Count the used elements equal to this lane's element; an unused lane counts zero
  always_comb begin
    cand_nxt.cnt = '0;
    cand_nxt.val = own_val;
    for (int j = 0; j < ppms_pkg::MAX_OPERANDS; j++) begin
      if (used[j] && (vals[j] == own_val)) begin
        cand_nxt.cnt = cand_nxt.cnt + ppms_pkg::CNT_W'(1);
      end
    end
    if (!own_used) begin
      cand_nxt.cnt = '0;
    end
  end

  // Hold the lane result until the stage advances
  always_ff @(posedge clk) begin
    if (en) begin
      cand_r <= cand_nxt;
    end
  end

endmodule

// ----- sv/ppms_node.sv -----
`timescale 1ns / 1ps

module ppms_node (
  input  logic            clk,
  input  logic            en,
  input  ppms_pkg::cand_t a,
  input  ppms_pkg::cand_t b,
  output ppms_pkg::cand_t y_r
);

  ppms_pkg::cand_t y_nxt;
  logic            take_a;

  // Keep the higher count; on equal counts keep the larger value
  always_comb begin
    take_a = (a.cnt > b.cnt) || ((a.cnt == b.cnt) && (a.val >= b.val));
    y_nxt  = take_a ? a : b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

endmodule

// ----- test/per_pixel_mode_select_core_tb.sv -----
`timescale 1ns / 1ps

module per_pixel_mode_select_core_tb;

  typedef logic [ppms_pkg::MAX_OPERANDS-1:0][ppms_pkg::VALUE_WIDTH-1:0] lanes_t;

  // One expected result: the mode and its null marker
  typedef struct packed {
    ppms_pkg::val_t val;
    logic           is_null;
  } mode_res_t;

  // One directed pixel, with an optional hand-typed result
  typedef struct packed {
    logic [ppms_pkg::CFG_W-1:0]        count;
    lanes_t                            lanes;
    logic [ppms_pkg::MAX_OPERANDS-1:0] flags;
    logic                              known;
    ppms_pkg::val_t                    want_val;
    logic                              want_null;
  } pixel_row_t;

  // Operand count per random phase, phase 0 in the lowest nibble
  localparam logic [11:0][ppms_pkg::CFG_W-1:0] PHASE_COUNTS = {
    4'd12, 4'd9, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd15, 4'd0, 4'd8, 4'd1
  };
  localparam int PHASE_PIXELS = 150;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  lanes_t                            pix_lanes;
  logic [ppms_pkg::MAX_OPERANDS-1:0] pix_flags;
  logic                              out_valid;
  logic                              out_stall;
  ppms_pkg::val_t                    out_mode_value;
  logic                              out_result_null;
  logic                              cfg_write_en;
  logic [ppms_pkg::CFG_W-1:0]        cfg_write_data;

  // Hand-typed result travelling with the pixel on the input channel
  logic                              tag_known;
  ppms_pkg::val_t                    tag_val;
  logic                              tag_null;

  logic [ppms_pkg::CFG_W-1:0]        op_count;
  mode_res_t                         pending_modes[$];
  pixel_row_t                        dir_rows[$];
  int                                mismatches;
  int                                pixels_sent;
  bit                                send_steady;

  per_pixel_mode_select_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value_0      (pix_lanes[0]),
    .in_value_1      (pix_lanes[1]),
    .in_value_2      (pix_lanes[2]),
    .in_value_3      (pix_lanes[3]),
    .in_value_4      (pix_lanes[4]),
    .in_value_5      (pix_lanes[5]),
    .in_value_6      (pix_lanes[6]),
    .in_value_7      (pix_lanes[7]),
    .in_null_flags   (pix_flags),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mode_value  (out_mode_value),
    .out_result_null (out_result_null),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Most frequent used value, larger value wins a tie; null if any used lane is null
  function automatic mode_res_t pixel_mode(
      input lanes_t lanes,
      input logic [ppms_pkg::MAX_OPERANDS-1:0] flags,
      input logic [ppms_pkg::CFG_W-1:0] count);
    int             used;
    int             hits;
    int             best_hits;
    ppms_pkg::val_t cur;
    ppms_pkg::val_t best;
    mode_res_t      res;
    used = (count == 0) ? 1 :
           (count > ppms_pkg::MAX_OPERANDS) ? ppms_pkg::MAX_OPERANDS : int'(count);
    res.val = '0;
    res.is_null = 1'b0;
    for (int i = 0; i < used; i++) begin
      if (flags[i]) res.is_null = 1'b1;
    end
    if (res.is_null) return res;
    best_hits = 0;
    best = '0;
    for (int i = 0; i < used; i++) begin
      cur = lanes[i];
      hits = 0;
      for (int j = 0; j < used; j++) begin
        if (ppms_pkg::val_t'(lanes[j]) == cur) hits++;
      end
      if (hits > best_hits || (hits == best_hits && cur > best)) begin
        best_hits = hits;
        best = cur;
      end
    end
    res.val = best;
    return res;
  endfunction

  function automatic void add_row(
      input logic [ppms_pkg::CFG_W-1:0] count,
      input ppms_pkg::val_t v0, input ppms_pkg::val_t v1, input ppms_pkg::val_t v2,
      input ppms_pkg::val_t v3, input ppms_pkg::val_t v4, input ppms_pkg::val_t v5,
      input ppms_pkg::val_t v6, input ppms_pkg::val_t v7,
      input logic [ppms_pkg::MAX_OPERANDS-1:0] flags,
      input logic known, input ppms_pkg::val_t want_val,
      input logic want_null);
    pixel_row_t row;
    row.count = count;
    row.lanes = {v7, v6, v5, v4, v3, v2, v1, v0};
    row.flags = flags;
    row.known = known;
    row.want_val = want_val;
    row.want_null = want_null;
    dir_rows.push_back(row);
  endfunction

  // Offer one pixel after a random gap and hold it until the transaction completes
  task automatic offer_pixel(input lanes_t lanes,
                             input logic [ppms_pkg::MAX_OPERANDS-1:0] flags,
                             input logic known, input ppms_pkg::val_t want_val,
                             input logic want_null);
    int gap;
    if (pixels_sent % 50 == 0) send_steady = ($urandom_range(0, 3) == 0);
    gap = send_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_lanes <= lanes;
    pix_flags <= flags;
    tag_known <= known;
    tag_val   <= want_val;
    tag_null  <= want_null;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // Drop valid and wait until every outstanding pixel has come back
  task automatic drain_pixels();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_modes.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_operand_count(input logic [ppms_pkg::CFG_W-1:0] count);
    drain_pixels();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= count;
    op_count       <= count;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Stimulus: directed table, then random phases at several operand counts
  initial begin : stimulus
    pixel_row_t                        row;
    ppms_pkg::val_t                    pool [4];
    int                                kinds;
    lanes_t                            lanes;
    logic [ppms_pkg::MAX_OPERANDS-1:0] flags;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    pix_lanes      = '0;
    pix_flags      = '0;
    tag_known      = 1'b0;
    tag_val        = '0;
    tag_null       = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = ppms_pkg::CFG_RESET;
    op_count       = ppms_pkg::CFG_RESET;
    mismatches     = 0;
    pixels_sent    = 0;
    send_steady    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset count: uniform, all distinct, nulls, extremes, ties
    add_row(8, 5, 5, 5, 5, 5, 5, 5, 5, 8'h00, 1, 5, 0);
    add_row(8, 1, 2, 3, 4, 5, 6, 7, 8, 8'h00, 1, 8, 0);
    add_row(8, 4, 4, 4, 4, 4, 4, 4, 4, 8'h80, 1, 0, 1);
    add_row(8, -1, 7, -9, 3, 3, 3, 0, 2, 8'hFF, 1, 0, 1);
    add_row(8, 32'h7FFF_FFFF, 1, 2, 3, 4, 5, 6, -7, 8'h00, 1, 32'h7FFF_FFFF, 0);
    add_row(8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            8'h00, 1, 32'h8000_0000, 0);
    add_row(8, 3, 3, 9, 9, 9, 3, 1, 1, 8'h00, 0, 0, 0);
    add_row(8, -1, 100, -1, 100, -1, 100, -1, -1, 8'h00, 0, 0, 0);
    add_row(8, 32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h8000_0001,
            32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 32'h8000_0001,
            8'h00, 0, 0, 0);
    // Single operand: upper flags and lanes ignored
    add_row(1, 32'h8000_0001, 9, 9, 9, 9, 9, 9, 9, 8'hFE, 1, 32'h8000_0001, 0);
    add_row(1, 6, 6, 6, 6, 6, 6, 6, 6, 8'h01, 1, 0, 1);
    // Count zero behaves as one
    add_row(0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 8'hFE, 1, 32'h7FFF_FFFF, 0);
    add_row(0, 12, 12, 12, 12, 12, 12, 12, 12, 8'h01, 1, 0, 1);
    // Counts above eight saturate
    add_row(15, -8, -7, -6, -5, -4, -3, -2, -1, 8'h00, 0, 0, 0);
    add_row(15, 1, 1, 1, 1, 1, 1, 1, 1, 8'h80, 1, 0, 1);
    add_row(9, 2, 7, 2, 7, 7, 2, 5, 5, 8'h00, 0, 0, 0);
    // Partial counts: lanes past the count must not vote
    add_row(3, 2, 2, 5, 9, 9, 9, 9, 9, 8'hF8, 0, 0, 0);
    add_row(3, 2, 2, 5, 9, 9, 9, 9, 9, 8'h04, 1, 0, 1);
    add_row(4, -20, 30, -20, 30, 0, 0, 0, 0, 8'hF0, 0, 0, 0);
    add_row(2, -5, -3, -3, -3, -3, -3, -3, -3, 8'hFC, 0, 0, 0);
    add_row(7, 1, 2, 3, 4, 5, 6, 7, 8, 8'h40, 1, 0, 1);
    add_row(6, 11, -11, 11, -11, 0, 0, 9, 9, 8'hC0, 0, 0, 0);
    add_row(5, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0001, 32'h7FFF_FFFF, 4, 4, 4, 4,
            8'hE0, 0, 0, 0);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (row.count != op_count) set_operand_count(row.count);
      offer_pixel(row.lanes, row.flags, row.known, row.want_val, row.want_null);
    end

    // Random pixels drawn from small pools so that values repeat and tie
    for (int phase = 0; phase < 12; phase++) begin
      set_operand_count(PHASE_COUNTS[phase]);
      repeat (PHASE_PIXELS) begin
        for (int q = 0; q < 4; q++) begin
          case ($urandom_range(0, 5))
            0: pool[q] = 32'h7FFF_FFFF;
            1: pool[q] = 32'h8000_0001;
            2: pool[q] = 32'h8000_0000;
            3: pool[q] = $urandom_range(0, 6) - 3;
            default: pool[q] = $urandom;
          endcase
        end
        kinds = $urandom_range(1, 4);
        for (int i = 0; i < ppms_pkg::MAX_OPERANDS; i++) begin
          lanes[i] = ($urandom_range(0, 7) == 0) ? ppms_pkg::val_t'($urandom)
                                                 : pool[$urandom_range(0, kinds - 1)];
        end
        flags = ($urandom_range(0, 3) == 0) ?
                ppms_pkg::MAX_OPERANDS'($urandom_range(0, 255)) : '0;
        offer_pixel(lanes, flags, 1'b0, '0, 1'b0);
      end
    end

    drain_pixels();
    repeat (ppms_pkg::NUM_STAGES + 4) @(posedge clk);
    if (mismatches == 0 && pending_modes.size() == 0) begin
      $display("per_pixel_mode_select_core_tb: PASS");
    end else begin
      $display("per_pixel_mode_select_core_tb: FAIL");
    end
    $finish;
  end

  // Result side: random stalls, bursts without stalls, one long hold-off
  initial begin : result_sink
    int gap;
    int taken;
    bit steady;
    out_stall = 1'b0;
    taken = 0;
    steady = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 16);
      if (taken == 300) gap = 200;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Record a prediction per accepted pixel; compare each accepted result
  always @(posedge clk) begin : scoreboard
    mode_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (tag_known) begin
          want.val = tag_val;
          want.is_null = tag_null;
        end else begin
          want = pixel_mode(pix_lanes, pix_flags, op_count);
        end
        pending_modes.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_modes.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, actual mode %0d null %0b", $time,
                   out_mode_value, out_result_null);
        end else begin
          want = pending_modes.pop_front();
          if (out_mode_value !== want.val) begin
            mismatches++;
            $display("%0t: mode_value expected %0d actual %0d", $time,
                     want.val, out_mode_value);
          end
          if (out_result_null !== want.is_null) begin
            mismatches++;
            $display("%0t: result_null expected %0b actual %0b", $time,
                     want.is_null, out_result_null);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("per_pixel_mode_select_core_tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ppms_pkg.sv
sv/ppms_lane.sv
sv/ppms_node.sv
sv/per_pixel_mode_select_core.sv
test/per_pixel_mode_select_core_tb.sv
